@@ hdl/preemptive_priority_scheduler_macros.svh @@
// Assertion macros for the scheduler.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PPS_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PPS_ASSERT(label, clk, rst_n, prop)
`define PPS_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ hdl/pps_pkg.sv @@
package pps_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusZero = 2'd2;
  localparam logic OpArrive = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  proc_id;
    logic [7:0]  proc_priority;
    logic [15:0] proc_burst;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] clock_now;
    logic        cpu_busy_out;
    logic [7:0]  running_id;
    logic        preempted;
    logic [7:0]  preempted_id;
    logic        finished;
    logic [7:0]  finished_id;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [15:0] response;
  } out_t;

  // One process record as held in the list and on the CPU.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] first;
    logic        started;
    logic [15:0] total;
    logic [15:0] remaining;
  } proc_t;

  typedef enum logic [2:0] {
    StIdle, StPop, StScan, StShift, StWrite, StTick, StDone
  } state_e;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
  } mem_ctl_t;
endpackage

@@ hdl/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler. Takes arrival and tick items one at a time and returns one
// result item for each. The ready list sits in a memory with one registered read port and one
// write port, and a small sequencer walks it one entry at a time. A rejected arrival skips the
// list and goes straight to the result. An accepted arrival does a read and a compare per entry
// to find the insert point, then a read and a write per entry moved up. A tick with an empty
// list or a CPU that keeps running leaves the list as it is; a tick that dispatches takes the
// head out and shifts the rest down one a cycle; a preempting tick also reinserts the displaced
// process. The next item is accepted only once the previous result has been taken, or in the
// cycle in which it is taken.
module preemptive_priority_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pps_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pps_pkg::out_t  out_data_o
);
  `include "preemptive_priority_scheduler_macros.svh"
  localparam int unsigned IdxW = pps_pkg::IdxW;
  localparam int unsigned CntW = pps_pkg::CntW;

  pps_pkg::state_e state_q, state_d;
  pps_pkg::in_t    item_q, item_d;
  pps_pkg::proc_t  run_q, run_d, ins_q, ins_d, head_q, head_d, rd_data, wr_data;
  pps_pkg::mem_ctl_t ctl;
  logic            busy_q, busy_d, pre_q, pre_d, insert_q, insert_d;
  logic [7:0]      pre_id_q, pre_id_d;
  logic [CntW-1:0] count_q, count_d, ptr_q, ptr_d, pos_q, pos_d;
  logic [15:0]     clock_q, clock_d;
  logic            out_valid_q, out_valid_d;
  pps_pkg::out_t   out_q, out_d;
  logic            rd_pend_q, rd_pend_d;

  pps_list_mem u_mem (.clk_i, .ctl_i(ctl), .wr_data_i(wr_data), .rd_data_o(rd_data));

  assign in_ready_o  = (state_q == pps_pkg::StIdle) && !(out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::StIdle;
      busy_q <= 1'b0;
      count_q <= '0;
      clock_q <= '0;
      run_q <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= busy_d;
      count_q <= count_d;
      clock_q <= clock_d;
      run_q <= run_d;
      out_valid_q <= out_valid_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ins_q <= ins_d;
    head_q <= head_d;
    pre_q <= pre_d;
    pre_id_q <= pre_id_d;
    insert_q <= insert_d;
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    out_q <= out_d;
  end

  // Scan and shift steps each need a read whose data arrives in the cycle after;
  // rd_pend_q marks the cycle in which rd_data holds the entry at ptr_q (ptr_q - 1 in
  // StShift). In StPop it marks only the first cycle, as the shift down reads every cycle.
  always_comb begin
    logic [15:0] tat;
    state_d = state_q; item_d = item_q; run_d = run_q; ins_d = ins_q; head_d = head_q;
    busy_d = busy_q; pre_d = pre_q; pre_id_d = pre_id_q; insert_d = insert_q;
    count_d = count_q; ptr_d = ptr_q; pos_d = pos_q; clock_d = clock_q;
    out_valid_d = out_valid_q && !out_ready_i; out_d = out_q; rd_pend_d = 1'b0;
    ctl = '0; wr_data = ins_q; tat = '0;
    unique case (state_q)
      pps_pkg::StIdle: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_data_i; pre_d = 1'b0; pre_id_d = '0; insert_d = 1'b0;
          ins_d = '{id: in_data_i.proc_id, prio: in_data_i.proc_priority,
                    arrival: clock_q, first: 16'd0, started: 1'b0,
                    total: in_data_i.proc_burst, remaining: in_data_i.proc_burst};
          ptr_d = '0;
          if (in_data_i.op == pps_pkg::OpArrive) begin
            if (count_q >= CntW'(pps_pkg::QueueDepth) || in_data_i.proc_burst == 16'd0) begin
              state_d = pps_pkg::StDone;
            end else begin
              insert_d = 1'b1; state_d = pps_pkg::StScan;
            end
          end else if (count_q != '0) begin
            ctl.rd_en = 1'b1; ctl.rd_addr = '0; rd_pend_d = 1'b1;
            state_d = pps_pkg::StPop;
          end else begin
            state_d = pps_pkg::StTick;
          end
        end
      end
      pps_pkg::StPop: begin
        // First cycle: rd_data holds the head; decide what happens to it.
        if (rd_pend_q) begin
          head_d = rd_data;
          if (busy_q && rd_data.prio < run_q.prio) begin
            pre_d = 1'b1; pre_id_d = run_q.id; ins_d = run_q; insert_d = 1'b1;
            ptr_d = CntW'(1);
            ctl.rd_en = 1'b1; ctl.rd_addr = IdxW'(1); rd_pend_d = 1'b1;
          end else if (!busy_q) begin
            ptr_d = CntW'(1);
            ctl.rd_en = 1'b1; ctl.rd_addr = IdxW'(1); rd_pend_d = 1'b1;
          end else begin
            state_d = pps_pkg::StTick;
          end
          if (!(busy_q && rd_data.prio < run_q.prio) && busy_q) begin
            state_d = pps_pkg::StTick;
          end else if (count_q == CntW'(1)) begin
            rd_pend_d = 1'b0; ptr_d = '0; count_d = '0;
            busy_d = 1'b1; run_d = rd_data;
            state_d = (busy_q && rd_data.prio < run_q.prio) ? pps_pkg::StScan
                                                              : pps_pkg::StTick;
          end
        end else begin
          // Shift entry ptr_q down to ptr_q - 1, one per cycle.
          ctl.wr_en = 1'b1; ctl.wr_addr = IdxW'(ptr_q - CntW'(1)); wr_data = rd_data;
          if (ptr_q + CntW'(1) >= count_q) begin
            count_d = count_q - CntW'(1); ptr_d = '0;
            busy_d = 1'b1; run_d = head_q;
            state_d = pre_q ? pps_pkg::StScan : pps_pkg::StTick;
          end else begin
            ptr_d = ptr_q + CntW'(1);
            ctl.rd_en = 1'b1; ctl.rd_addr = IdxW'(ptr_q + CntW'(1));
          end
        end
        if (rd_pend_q && ptr_d != '0 && state_d == pps_pkg::StPop) begin
          rd_pend_d = 1'b0;
        end
      end
      pps_pkg::StScan: begin
        // Find the first entry strictly less urgent than ins_q.
        if (ptr_q >= count_q) begin
          pos_d = count_q; state_d = pps_pkg::StWrite;
        end else if (!rd_pend_q) begin
          ctl.rd_en = 1'b1; ctl.rd_addr = IdxW'(ptr_q); rd_pend_d = 1'b1;
        end else if (rd_data.prio > ins_q.prio) begin
          pos_d = ptr_q; ptr_d = count_q; state_d = pps_pkg::StShift;
        end else begin
          ptr_d = ptr_q + CntW'(1);
        end
      end
      pps_pkg::StShift: begin
        // Move entries pos_q .. count_q-1 up one, from the top down.
        if (ptr_q == pos_q) begin
          state_d = pps_pkg::StWrite;
        end else if (!rd_pend_q) begin
          ctl.rd_en = 1'b1; ctl.rd_addr = IdxW'(ptr_q - CntW'(1)); rd_pend_d = 1'b1;
        end else begin
          ctl.wr_en = 1'b1; ctl.wr_addr = IdxW'(ptr_q); wr_data = rd_data;
          ptr_d = ptr_q - CntW'(1);
        end
      end
      pps_pkg::StWrite: begin
        ctl.wr_en = 1'b1; ctl.wr_addr = IdxW'(pos_q); wr_data = ins_q;
        count_d = count_q + CntW'(1);
        state_d = (item_q.op == pps_pkg::OpTick) ? pps_pkg::StTick : pps_pkg::StDone;
      end
      pps_pkg::StTick: begin
        if (busy_q) begin
          if (!run_q.started) begin
            run_d.started = 1'b1; run_d.first = clock_q;
          end
          run_d.remaining = run_q.remaining - 16'd1;
        end
        clock_d = clock_q + 16'd1;
        state_d = pps_pkg::StDone;
      end
      pps_pkg::StDone: begin
        out_d = '0;
        out_d.kind = item_q.op;
        out_d.clock_now = clock_q;
        if (item_q.op == pps_pkg::OpArrive) begin
          if (!insert_q) begin
            out_d.status = (item_q.proc_burst == 16'd0 &&
                            count_q < CntW'(pps_pkg::QueueDepth)) ? pps_pkg::StatusZero
                                                                  : pps_pkg::StatusFull;
          end
        end else begin
          out_d.preempted = pre_q;
          out_d.preempted_id = pre_id_q;
          if (busy_q && run_q.remaining == 16'd0) begin
            tat = clock_q - run_q.arrival;
            out_d.finished = 1'b1;
            out_d.finished_id = run_q.id;
            out_d.turnaround = tat;
            out_d.waiting = tat - run_q.total;
            out_d.response = run_q.first - run_q.arrival;
            busy_d = 1'b0;
          end
        end
        out_d.cpu_busy_out = busy_d;
        out_d.running_id = busy_d ? run_q.id : 8'd0;
        out_valid_d = 1'b1;
        state_d = pps_pkg::StIdle;
      end
      default: state_d = pps_pkg::StIdle;
    endcase
  end

  `PPS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(pps_pkg::QueueDepth))
  `PPS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `PPS_ASSERT(a_done_result, clk_i, rst_ni, state_q == pps_pkg::StDone |=> out_valid_o)
endmodule

@@ hdl/pps_list_mem.sv @@
module pps_list_mem (
  input  logic              clk_i,
  input  pps_pkg::mem_ctl_t ctl_i,
  input  pps_pkg::proc_t    wr_data_i,
  output pps_pkg::proc_t    rd_data_o
);
  pps_pkg::proc_t mem_q [pps_pkg::QueueDepth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_o <= mem_q[ctl_i.rd_addr];
    end
  end
endmodule
